@@ design/swg_pkg.sv @@
// Shared types, codes and defaults of the sliding-window event guard.
package swg_pkg;

   localparam int DEF_NUM_FUNCTIONS   = 16;
   localparam int DEF_NUM_EVENT_TYPES = 6;
   localparam int DEF_MAX_RECORDS     = 32;
   localparam int DEF_TIME_BITS       = 48;

   typedef enum logic [2:0] {
      OP_ADD_EVENT   = 3'd0,
      OP_REMOVE      = 3'd1,
      OP_QUERY_EVENT = 3'd2,
      OP_QUERY_GEN   = 3'd3,
      OP_SET_EVENT   = 3'd4,
      OP_SET_GEN     = 3'd5,
      OP_RESET_FUNC  = 3'd6,
      OP_UNUSED      = 3'd7
   } op_type;

   localparam logic [1:0] ST_NORMAL   = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;
   localparam logic [1:0] ST_INVALID  = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FAIL     = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_EX_RD,
      S_EX_LOAD,
      S_EX_TEST,
      S_EX_CMP,
      S_EX_WB,
      S_OP_RD,
      S_OP_LOAD,
      S_OP_EXEC,
      S_FINISH,
      S_RESP
   } ctl_state_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  function_index;
      logic [2:0]  event_type;
      logic [47:0] now;
      logic [5:0]  new_threshold;
      logic [47:0] new_interval;
      logic [1:0]  new_state;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  event_state;
      logic        guard_enabled;
      logic [5:0]  active_count;
      logic [31:0] total_count;
      logic [5:0]  threshold_value;
      logic [47:0] interval_value;
      logic [31:0] overflow_total;
   } rsp_type;

endpackage

@@ design/swg_entry_mem.sv @@
// Per-entry descriptor memory with a valid bit per entry; unwritten entries read as reset value.
module swg_entry_mem
   import swg_pkg::*;
#(
   parameter int DEPTH = 96,
   parameter int WIDTH = 128,
   parameter logic [WIDTH-1:0] INIT = '0,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff;
   logic             hit_ff;

   // mark entries written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
         hit_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : INIT;

endmodule

@@ design/swg_log_mem.sv @@
// Arrival timestamp ring storage, one write and one registered read port.
module swg_log_mem
   import swg_pkg::*;
#(
   parameter int DEPTH = 3072,
   parameter int WIDTH = 48,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

@@ design/swg_ctrl.sv @@
// Sequencer: expiry walk with a shared age comparator, operation execution and response.
module swg_ctrl
   import swg_pkg::*;
#(
   parameter int NUM_FUNCTIONS   = DEF_NUM_FUNCTIONS,
   parameter int NUM_EVENT_TYPES = DEF_NUM_EVENT_TYPES,
   parameter int MAX_RECORDS     = DEF_MAX_RECORDS,
   parameter int TIME_BITS       = DEF_TIME_BITS,
   localparam int NE  = NUM_FUNCTIONS * NUM_EVENT_TYPES,
   localparam int CW  = $clog2(MAX_RECORDS + 1),
   localparam int SW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1,
   localparam int TW  = TIME_BITS,
   localparam int EW  = TW + CW + 2 + 32 + SW + CW,
   localparam int EAW = (NE > 1) ? $clog2(NE) : 1,
   localparam int LAW = (NE * MAX_RECORDS > 1) ? $clog2(NE * MAX_RECORDS) : 1
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp,
   output logic           ent_rd_en,
   output logic [EAW-1:0] ent_rd_addr,
   input  logic [EW-1:0]  ent_rd_data,
   output logic           ent_wr_en,
   output logic [EAW-1:0] ent_wr_addr,
   output logic [EW-1:0]  ent_wr_data,
   output logic           log_rd_en,
   output logic [LAW-1:0] log_rd_addr,
   input  logic [TW-1:0]  log_rd_data,
   output logic           log_wr_en,
   output logic [LAW-1:0] log_wr_addr,
   output logic [TW-1:0]  log_wr_data
);

   localparam int FW  = (NUM_FUNCTIONS > 1) ? $clog2(NUM_FUNCTIONS) : 1;
   localparam int TTW = (NUM_EVENT_TYPES > 1) ? $clog2(NUM_EVENT_TYPES) : 1;
   localparam int O_OLD = CW;
   localparam int O_ACC = CW + SW;
   localparam int O_ST  = CW + SW + 32;
   localparam int O_THR = CW + SW + 34;
   localparam int O_INT = CW + SW + 34 + CW;

   ctl_state_type state_ff, state_in;
   req_type       req_ff, req_in;
   logic [1:0]    status_ff, status_in;
   logic          go_ff, go_in;
   logic          rok_ff, rok_in;
   logic [TTW-1:0] t_cnt_ff, t_cnt_in;

   // working entry
   logic [CW-1:0] cur_act_ff, cur_act_in;
   logic [SW-1:0] cur_old_ff, cur_old_in;
   logic [31:0]   cur_acc_ff, cur_acc_in;
   logic [1:0]    cur_st_ff, cur_st_in;
   logic [CW-1:0] cur_thr_ff, cur_thr_in;
   logic [TW-1:0] cur_int_ff, cur_int_in;

   // captured response entry
   logic [CW-1:0] r_act_ff, r_act_in;
   logic [31:0]   r_acc_ff, r_acc_in;
   logic [1:0]    r_st_ff, r_st_in;
   logic [CW-1:0] r_thr_ff, r_thr_in;
   logic [TW-1:0] r_int_ff, r_int_in;

   logic [NUM_FUNCTIONS-1:0] enabled_ff, enabled_in;
   logic [31:0]              rejected_ff [NUM_FUNCTIONS];
   logic [31:0]              rejected_in [NUM_FUNCTIONS];

   logic          fval, tval;
   logic [FW-1:0] fidx;
   logic [TTW-1:0] treq;
   op_type        op;
   logic [TW-1:0] now_t;
   logic [TW-1:0] age;
   logic [EAW-1:0] ent_addr;
   logic [CW:0]   slot_sum;
   logic [SW-1:0] wslot;
   logic [SW-1:0] old_next;
   logic          last_t;

   assign op     = op_type'(req_ff.operation);
   assign fval   = int'(req_ff.function_index) < NUM_FUNCTIONS;
   assign tval   = int'(req_ff.event_type) < NUM_EVENT_TYPES;
   assign fidx   = FW'(req_ff.function_index);
   assign treq   = TTW'(req_ff.event_type);
   assign now_t  = TW'(req_ff.now);
   assign last_t = (int'(t_cnt_ff) == NUM_EVENT_TYPES - 1);
   assign ent_addr = EAW'(int'(fidx) * NUM_EVENT_TYPES + int'(t_cnt_ff));

   // shared age comparator operand and ring arithmetic
   assign age      = now_t - log_rd_data;
   assign old_next = (int'(cur_old_ff) == MAX_RECORDS - 1) ? '0 : cur_old_ff + 1'b1;
   assign slot_sum = (CW+1)'(cur_old_ff) + (CW+1)'(cur_act_ff);
   assign wslot    = (slot_sum >= (CW+1)'(MAX_RECORDS)) ?
                     SW'(slot_sum - (CW+1)'(MAX_RECORDS)) : SW'(slot_sum);

   // memory addresses and write data
   assign ent_rd_addr = ent_addr;
   assign ent_wr_addr = ent_addr;
   assign ent_wr_data = {cur_int_in, cur_thr_in, cur_st_in, cur_acc_in, cur_old_in, cur_act_in};
   assign log_wr_data = now_t;

   // next state and datapath
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      status_in  = status_ff;
      go_in      = go_ff;
      rok_in     = rok_ff;
      t_cnt_in   = t_cnt_ff;
      cur_act_in = cur_act_ff;
      cur_old_in = cur_old_ff;
      cur_acc_in = cur_acc_ff;
      cur_st_in  = cur_st_ff;
      cur_thr_in = cur_thr_ff;
      cur_int_in = cur_int_ff;
      r_act_in   = r_act_ff;
      r_acc_in   = r_acc_ff;
      r_st_in    = r_st_ff;
      r_thr_in   = r_thr_ff;
      r_int_in   = r_int_ff;
      enabled_in = enabled_ff;
      rejected_in = rejected_ff;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      ent_rd_en  = 1'b0;
      ent_wr_en  = 1'b0;
      log_rd_en  = 1'b0;
      log_wr_en  = 1'b0;
      log_rd_addr = LAW'(int'(ent_addr) * MAX_RECORDS + int'(cur_old_ff));
      log_wr_addr = LAW'(int'(ent_addr) * MAX_RECORDS + int'(wslot));

      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in   = req;
               state_in = S_DISPATCH;
            end
         end

         // decide what the item does
         S_DISPATCH: begin
            if (!fval) begin
               status_in = STATUS_FAIL;
               rok_in    = 1'b0;
               state_in  = S_RESP;
            end else begin
               rok_in = tval;
               unique case (op)
                  OP_ADD_EVENT:   go_in = tval && enabled_ff[fidx];
                  OP_REMOVE:      go_in = tval;
                  OP_QUERY_EVENT: go_in = tval;
                  OP_QUERY_GEN:   go_in = 1'b1;
                  OP_SET_EVENT:   go_in = tval && (int'(req_ff.new_threshold) <= MAX_RECORDS)
                                          && (req_ff.new_state != ST_INVALID);
                  OP_SET_GEN:     go_in = 1'b1;
                  OP_RESET_FUNC:  go_in = 1'b1;
                  default:        go_in = 1'b0;
               endcase
               status_in = go_in ? STATUS_OK : STATUS_FAIL;
               if (go_in && (op == OP_ADD_EVENT || op == OP_QUERY_EVENT ||
                             op == OP_QUERY_GEN)) begin
                  t_cnt_in = '0;
                  state_in = S_EX_RD;
               end else if (op == OP_RESET_FUNC) begin
                  t_cnt_in = '0;
                  state_in = S_OP_RD;
               end else if (tval) begin
                  t_cnt_in = treq;
                  state_in = S_OP_RD;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         // expiry walk over the function's event types
         S_EX_RD: begin
            ent_rd_en = 1'b1;
            state_in  = S_EX_LOAD;
         end

         S_EX_LOAD: begin
            cur_act_in = ent_rd_data[CW-1:0];
            cur_old_in = ent_rd_data[O_OLD +: SW];
            cur_acc_in = ent_rd_data[O_ACC +: 32];
            cur_st_in  = ent_rd_data[O_ST +: 2];
            cur_thr_in = ent_rd_data[O_THR +: CW];
            cur_int_in = ent_rd_data[O_INT +: TW];
            state_in   = S_EX_TEST;
         end

         S_EX_TEST: begin
            if (cur_act_ff == '0) begin
               state_in = S_EX_WB;
            end else begin
               log_rd_en = 1'b1;
               state_in  = S_EX_CMP;
            end
         end

         // drop the oldest record once it has aged out
         S_EX_CMP: begin
            if (age < cur_int_ff) begin
               state_in = S_EX_WB;
            end else begin
               cur_act_in = cur_act_ff - 1'b1;
               cur_st_in  = ST_NORMAL;
               cur_old_in = old_next;
               state_in   = S_EX_TEST;
            end
         end

         S_EX_WB: begin
            ent_wr_en = 1'b1;
            if (!last_t) begin
               t_cnt_in = t_cnt_ff + 1'b1;
               state_in = S_EX_RD;
            end else if (tval) begin
               t_cnt_in = treq;
               state_in = S_OP_RD;
            end else begin
               state_in = S_FINISH;
            end
         end

         // operation on the addressed entry, or on every entry of the function for a reset
         S_OP_RD: begin
            ent_rd_en = 1'b1;
            state_in  = S_OP_LOAD;
         end

         S_OP_LOAD: begin
            cur_act_in = ent_rd_data[CW-1:0];
            cur_old_in = ent_rd_data[O_OLD +: SW];
            cur_acc_in = ent_rd_data[O_ACC +: 32];
            cur_st_in  = ent_rd_data[O_ST +: 2];
            cur_thr_in = ent_rd_data[O_THR +: CW];
            cur_int_in = ent_rd_data[O_INT +: TW];
            state_in   = S_OP_EXEC;
         end

         S_OP_EXEC: begin
            if (go_ff) begin
               unique case (op)
                  OP_ADD_EVENT: begin
                     if (cur_act_ff >= cur_thr_ff) begin
                        rejected_in[fidx] = rejected_ff[fidx] + 32'd1;
                        cur_st_in = ST_OVERFLOW;
                        status_in = STATUS_OVERFLOW;
                     end else begin
                        log_wr_en  = 1'b1;
                        cur_act_in = cur_act_ff + 1'b1;
                        cur_acc_in = cur_acc_ff + 32'd1;
                        if (cur_act_in == cur_thr_ff) begin
                           cur_st_in = ST_FULL;
                        end
                     end
                  end
                  OP_REMOVE: begin
                     if (enabled_ff[fidx] && cur_st_ff == ST_NORMAL && cur_act_ff != '0) begin
                        cur_act_in = cur_act_ff - 1'b1;
                     end
                  end
                  OP_SET_EVENT: begin
                     cur_st_in  = req_ff.new_state;
                     cur_int_in = TW'(req_ff.new_interval);
                     cur_thr_in = CW'(req_ff.new_threshold);
                  end
                  OP_RESET_FUNC: begin
                     cur_act_in = '0;
                     cur_old_in = '0;
                     cur_acc_in = '0;
                     cur_st_in  = ST_NORMAL;
                  end
                  default: ;
               endcase
            end
            ent_wr_en = 1'b1;
            if (tval && t_cnt_ff == treq) begin
               r_act_in = cur_act_in;
               r_acc_in = cur_acc_in;
               r_st_in  = cur_st_in;
               r_thr_in = cur_thr_in;
               r_int_in = cur_int_in;
            end
            if (op == OP_RESET_FUNC && !last_t) begin
               t_cnt_in = t_cnt_ff + 1'b1;
               state_in = S_OP_RD;
            end else begin
               state_in = S_FINISH;
            end
         end

         // function-wide updates
         S_FINISH: begin
            if (go_ff && op == OP_SET_GEN) begin
               enabled_in[fidx] = (req_ff.new_state != ST_NORMAL);
            end
            if (go_ff && op == OP_RESET_FUNC) begin
               rejected_in[fidx] = '0;
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control and per-function registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         enabled_ff <= '1;
         for (int i = 0; i < NUM_FUNCTIONS; i++) begin
            rejected_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         enabled_ff  <= enabled_in;
         rejected_ff <= rejected_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      status_ff  <= status_in;
      go_ff      <= go_in;
      rok_ff     <= rok_in;
      t_cnt_ff   <= t_cnt_in;
      cur_act_ff <= cur_act_in;
      cur_old_ff <= cur_old_in;
      cur_acc_ff <= cur_acc_in;
      cur_st_ff  <= cur_st_in;
      cur_thr_ff <= cur_thr_in;
      cur_int_ff <= cur_int_in;
      r_act_ff   <= r_act_in;
      r_acc_ff   <= r_acc_in;
      r_st_ff    <= r_st_in;
      r_thr_ff   <= r_thr_in;
      r_int_ff   <= r_int_in;
   end

   // build the result item
   always_comb begin
      rsp        = '0;
      rsp.status = status_ff;
      if (fval) begin
         rsp.guard_enabled  = enabled_ff[fidx];
         rsp.overflow_total = rejected_ff[fidx];
         if (rok_ff) begin
            rsp.event_state     = r_st_ff;
            rsp.active_count    = 6'(r_act_ff);
            rsp.total_count     = r_acc_ff;
            rsp.threshold_value = 6'(r_thr_ff);
            rsp.interval_value  = 48'(r_int_ff);
         end
      end
   end

endmodule

@@ design/sliding_window_event_guard.sv @@
// Sliding-window event guard: one item at a time; an accepted query or add first walks every
// event type of the function (read, load, then test and compare record by record, write back),
// then reads, loads and executes on the entry, does the function update and holds the result
// stage; other items skip the walk (reset function repeats the entry steps for each type). The
// next item is taken the cycle after the result leaves. Reset is synchronous: all entries read
// as their reset values at once.
module sliding_window_event_guard
   import swg_pkg::*;
#(
   parameter int NUM_FUNCTIONS   = DEF_NUM_FUNCTIONS,
   parameter int NUM_EVENT_TYPES = DEF_NUM_EVENT_TYPES,
   parameter int MAX_RECORDS     = DEF_MAX_RECORDS,
   parameter int TIME_BITS       = DEF_TIME_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   localparam int NE  = NUM_FUNCTIONS * NUM_EVENT_TYPES;
   localparam int CW  = $clog2(MAX_RECORDS + 1);
   localparam int SW  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int TW  = TIME_BITS;
   localparam int EW  = TW + CW + 2 + 32 + SW + CW;
   localparam int EAW = (NE > 1) ? $clog2(NE) : 1;
   localparam int LAW = (NE * MAX_RECORDS > 1) ? $clog2(NE * MAX_RECORDS) : 1;
   localparam logic [EW-1:0] ENTRY_INIT =
      {TW'(0), CW'(MAX_RECORDS), ST_NORMAL, 32'd0, SW'(0), CW'(0)};

   logic           ent_rd_en, ent_wr_en, log_rd_en, log_wr_en;
   logic [EAW-1:0] ent_rd_addr, ent_wr_addr;
   logic [EW-1:0]  ent_rd_data, ent_wr_data;
   logic [LAW-1:0] log_rd_addr, log_wr_addr;
   logic [TW-1:0]  log_rd_data, log_wr_data;

   swg_ctrl #(
      .NUM_FUNCTIONS  (NUM_FUNCTIONS),
      .NUM_EVENT_TYPES(NUM_EVENT_TYPES),
      .MAX_RECORDS    (MAX_RECORDS),
      .TIME_BITS      (TIME_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp         (rsp),
      .ent_rd_en   (ent_rd_en),
      .ent_rd_addr (ent_rd_addr),
      .ent_rd_data (ent_rd_data),
      .ent_wr_en   (ent_wr_en),
      .ent_wr_addr (ent_wr_addr),
      .ent_wr_data (ent_wr_data),
      .log_rd_en   (log_rd_en),
      .log_rd_addr (log_rd_addr),
      .log_rd_data (log_rd_data),
      .log_wr_en   (log_wr_en),
      .log_wr_addr (log_wr_addr),
      .log_wr_data (log_wr_data)
   );

   swg_entry_mem #(
      .DEPTH(NE),
      .WIDTH(EW),
      .INIT (ENTRY_INIT)
   ) u_entry_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (ent_rd_en),
      .rd_addr(ent_rd_addr),
      .rd_data(ent_rd_data),
      .wr_en  (ent_wr_en),
      .wr_addr(ent_wr_addr),
      .wr_data(ent_wr_data)
   );

   swg_log_mem #(
      .DEPTH(NE * MAX_RECORDS),
      .WIDTH(TW)
   ) u_log_mem (
      .clock  (clock),
      .rd_en  (log_rd_en),
      .rd_addr(log_rd_addr),
      .rd_data(log_rd_data),
      .wr_en  (log_wr_en),
      .wr_addr(log_wr_addr),
      .wr_data(log_wr_data)
   );

endmodule

@@ sim/tb_sliding_window_event_guard.sv @@
// Testbench for the sliding-window event guard: random and directed items checked against a predictor.
`timescale 1ns / 1ps

module tb_sliding_window_event_guard;
   import swg_pkg::*;

   localparam int NFUNC = DEF_NUM_FUNCTIONS;
   localparam int NTYPE = DEF_NUM_EVENT_TYPES;
   localparam int NREC  = DEF_MAX_RECORDS;
   localparam int NENT  = NFUNC * NTYPE;
   localparam longint CYCLE_LIMIT = 4000000;

   // guard state mirror and expected-result store
   class guard_scoreboard;
      logic [47:0] stamps [NENT*NREC];
      logic [5:0]  active [NENT];
      logic [4:0]  oldest [NENT];
      logic [31:0] accepted [NENT];
      logic [1:0]  estate [NENT];
      logic [5:0]  thresh [NENT];
      logic [47:0] window [NENT];
      logic        enabled [NFUNC];
      logic [31:0] rejected [NFUNC];
      rsp_type     pending [$];
      int          mismatches;

      function void clear_all();
         for (int i = 0; i < NENT; i++) begin
            active[i] = '0; oldest[i] = '0; accepted[i] = '0;
            estate[i] = ST_NORMAL; thresh[i] = 6'(NREC); window[i] = '0;
         end
         for (int i = 0; i < NFUNC; i++) begin
            enabled[i] = 1'b1; rejected[i] = '0;
         end
         mismatches = 0;
      endfunction

      // drop aged records of every event type of a function
      function void age_out(int f, logic [47:0] now);
         int e;
         logic [47:0] age;
         for (int t = 0; t < NTYPE; t++) begin
            e = f * NTYPE + t;
            while (active[e] > 0) begin
               age = now - stamps[e*NREC + oldest[e]];
               if (age < window[e]) break;
               active[e]--;
               estate[e] = ST_NORMAL;
               oldest[e] = oldest[e] + 5'd1;
            end
         end
      endfunction

      function void note_item(req_type r);
         rsp_type o;
         int f, e;
         bit tok;
         logic [1:0] st;
         o = '0;
         f = r.function_index;
         tok = r.event_type < NTYPE;
         e = tok ? f * NTYPE + r.event_type : 0;
         st = STATUS_FAIL;
         case (op_type'(r.operation))
            OP_ADD_EVENT: if (tok && enabled[f]) begin
               age_out(f, r.now);
               if (active[e] >= thresh[e]) begin
                  rejected[f]++;
                  estate[e] = ST_OVERFLOW;
                  st = STATUS_OVERFLOW;
               end else begin
                  stamps[e*NREC + ((oldest[e] + active[e]) % NREC)] = r.now;
                  active[e]++;
                  accepted[e]++;
                  if (active[e] == thresh[e]) estate[e] = ST_FULL;
                  st = STATUS_OK;
               end
            end
            OP_REMOVE: if (tok) begin
               if (enabled[f] && estate[e] == ST_NORMAL && active[e] > 0) active[e]--;
               st = STATUS_OK;
            end
            OP_QUERY_EVENT: if (tok) begin
               age_out(f, r.now);
               st = STATUS_OK;
            end
            OP_QUERY_GEN: begin
               age_out(f, r.now);
               st = STATUS_OK;
            end
            OP_SET_EVENT: if (tok && r.new_threshold <= NREC && r.new_state != ST_INVALID) begin
               estate[e] = r.new_state;
               window[e] = r.new_interval;
               thresh[e] = r.new_threshold;
               st = STATUS_OK;
            end
            OP_SET_GEN: begin
               enabled[f] = r.new_state != 0;
               st = STATUS_OK;
            end
            OP_RESET_FUNC: begin
               for (int j = 0; j < NTYPE; j++) begin
                  active[f*NTYPE+j] = '0; oldest[f*NTYPE+j] = '0;
                  accepted[f*NTYPE+j] = '0; estate[f*NTYPE+j] = ST_NORMAL;
               end
               rejected[f] = '0;
               st = STATUS_OK;
            end
            default: ;
         endcase
         o.status = st;
         o.guard_enabled = enabled[f];
         o.overflow_total = rejected[f];
         if (tok) begin
            o.event_state = estate[e];
            o.active_count = active[e];
            o.total_count = accepted[e];
            o.threshold_value = thresh[e];
            o.interval_value = window[e];
         end
         pending.push_back(o);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %h actual %h", want, got);
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp;

   guard_scoreboard board = new();
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   logic long_hold = 0;
   logic hold_on = 0;
   longint cycles = 0;

   sliding_window_event_guard DUT (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // check accepted results and drive the receiver stall
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp);
      if (hold_on) begin
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // hold the receiver off for a long stretch once asked
   initial begin
      wait (long_hold);
      @(posedge clock);
      hold_on <= 1;
      repeat (300) @(posedge clock);
      hold_on <= 0;
   end

   // end the run on a hung block
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // offer one item, with random idle before it, and wait for acceptance
   task automatic send_item(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_item(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   // mostly adds on a few functions with small windows, plus noise
   function automatic req_type rand_item(logic [47:0] now);
      req_type r;
      int k;
      r.now = now;
      r.function_index = 4'($urandom_range(3) == 0 ? $urandom_range(15) : $urandom_range(2));
      r.event_type = 3'($urandom_range(9) == 0 ? $urandom_range(7) : $urandom_range(1));
      r.new_threshold = 6'($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(6));
      r.new_interval = $urandom_range(9) == 0 ? rand48() : 48'($urandom_range(60));
      r.new_state = 2'($urandom_range(9) == 0 ? $urandom_range(3) : 0);
      k = $urandom_range(99);
      if (k < 55) r.operation = OP_ADD_EVENT;
      else if (k < 65) r.operation = OP_REMOVE;
      else if (k < 73) r.operation = OP_QUERY_EVENT;
      else if (k < 78) r.operation = OP_QUERY_GEN;
      else if (k < 88) r.operation = OP_SET_EVENT;
      else if (k < 92) r.operation = OP_SET_GEN;
      else if (k < 96) r.operation = OP_RESET_FUNC;
      else r.operation = OP_UNUSED;
      if (r.operation == OP_SET_GEN && $urandom_range(3) != 0) r.new_state = 2'd1;
      if ($urandom_range(30) == 0) r.now = rand48();
      return r;
   endfunction

   initial begin
      req_type r;
      logic [47:0] clk_now;
      board.clear_all();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, every operation and special cases
      r = '0;
      r.operation = OP_ADD_EVENT; r.now = '1; send_item(r);
      r.event_type = 3'(NTYPE - 1); r.function_index = 4'(NFUNC - 1); send_item(r);
      r.operation = OP_SET_EVENT; r.new_threshold = 6'd2; r.new_interval = 48'd5;
      r.new_state = ST_NORMAL; r.function_index = 4'd1; r.event_type = 3'd0; send_item(r);
      r.operation = OP_ADD_EVENT; r.now = 48'd100; send_item(r);
      send_item(r);
      send_item(r);                          // threshold reached: overflow
      r.operation = OP_REMOVE; send_item(r); // not normal: no drop
      r.operation = OP_QUERY_EVENT; r.now = 48'd105; send_item(r);
      r.operation = OP_ADD_EVENT; r.now = 48'd3; send_item(r); // time wraps back
      r.operation = OP_REMOVE; send_item(r);
      r.operation = OP_SET_EVENT; r.new_threshold = 6'd0; r.new_interval = '1;
      r.new_state = ST_FULL; send_item(r);
      r.operation = OP_ADD_EVENT; send_item(r); // zero threshold overflows
      r.operation = OP_SET_EVENT; r.new_threshold = 6'd33; send_item(r); // rejected
      r.new_threshold = 6'd63; send_item(r);
      r.new_threshold = 6'(NREC); r.new_state = ST_INVALID; send_item(r);
      r.new_state = ST_OVERFLOW; send_item(r);
      r.operation = OP_QUERY_GEN; r.event_type = 3'd7; send_item(r);
      r.operation = OP_ADD_EVENT; send_item(r); // bad event type
      r.operation = OP_SET_GEN; r.new_state = 2'd0; send_item(r);
      r.operation = OP_ADD_EVENT; r.event_type = 3'd1; send_item(r); // disabled
      r.operation = OP_REMOVE; send_item(r);
      r.operation = OP_SET_GEN; r.new_state = 2'd2; send_item(r);
      r.operation = OP_RESET_FUNC; send_item(r);
      r.operation = OP_UNUSED; send_item(r);
      drain();

      // random phases with varying idle pressure
      clk_now = '0;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (ph == 4) long_hold = 1; // long receiver hold-off stalls the block
         for (int i = 0; i < 190; i++) begin
            clk_now = clk_now + $urandom_range(4);
            send_item(rand_item(clk_now));
         end
         drain();
      end

      req_valid <= 0;
      repeat (500) @(posedge clock);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
